/* rtl/core/frame_history_nearest_match_assert.svh */
// assertion macros for the frame history block
`ifndef FRAME_HISTORY_NEAREST_MATCH_ASSERT_SVH
`define FRAME_HISTORY_NEAREST_MATCH_ASSERT_SVH
`ifndef SYNTHESIS
`define FHNM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define FHNM_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FHNM_ASSERT(label, clk, rst_n, prop)
`define FHNM_ASSERT_NORST(label, clk, prop)
`endif
`endif

/* rtl/core/fhnm_pkg.sv */
package fhnm_pkg;

  localparam int unsigned MemoryFramesDefault = 8;
  localparam int unsigned MaxObjectsDefault   = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgDistLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRatioTol  = 1'b1;

  localparam logic [11:0] DistLimitReset = 12'd20;
  localparam logic [15:0] RatioTolReset  = 16'd410;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpCommit = 2'd1,
    OpQuery  = 2'd2,
    OpNop    = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] center_x;
    logic [11:0] center_y;
    logic [15:0] shape_ratio;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  frame_position;
    logic [7:0]  object_slot;
    logic [11:0] match_x;
    logic [11:0] match_y;
    logic [15:0] match_ratio;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] ratio;
  } obj_t;

endpackage

/* rtl/core/fhnm_queue.sv */
// two-entry queue between the front and the back
module fhnm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fhnm_pkg::in_item_t push_data_i,
  output logic               full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output fhnm_pkg::in_item_t pop_data_o
);
  fhnm_pkg::in_item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (pop_i && !empty_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end
endmodule

/* rtl/core/fhnm_back.sv */
`include "frame_history_nearest_match_assert.svh"
// back end: object store, ring bookkeeping and the query walk
module fhnm_back #(
  parameter int unsigned MemoryFrames = fhnm_pkg::MemoryFramesDefault,
  parameter int unsigned MaxObjects   = fhnm_pkg::MaxObjectsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [11:0]           dist_limit_i,
  input  logic [15:0]           ratio_tol_i,
  input  logic                  cmd_valid_i,
  input  fhnm_pkg::in_item_t    cmd_i,
  output logic                  cmd_pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output fhnm_pkg::out_item_t   res_o
);
  localparam int unsigned FW = (MemoryFrames > 1) ? $clog2(MemoryFrames) : 1;
  localparam int unsigned OW = (MaxObjects > 1) ? $clog2(MaxObjects) : 1;
  localparam int unsigned CW = $clog2(MaxObjects + 1);
  localparam int unsigned NW = $clog2(MemoryFrames + 1);
  localparam int unsigned Depth = MemoryFrames * MaxObjects;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [FW-1:0] LastFrame = FW'(MemoryFrames - 1);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StCopy  = 6'b000010,
    StRead  = 6'b000100,
    StEval  = 6'b001000,
    StEmit  = 6'b010000,
    StWait  = 6'b100000
  } st_e;

  st_e state_q, state_d;

  fhnm_pkg::obj_t store_mem [Depth];
  fhnm_pkg::obj_t pend_mem  [MaxObjects];
  fhnm_pkg::obj_t store_rd_q, pend_rd_q;

  logic [CW-1:0] cnt_q [MemoryFrames];
  logic [FW-1:0] head_q;
  logic [NW-1:0] stored_q;
  logic [CW-1:0] pend_cnt_q;

  logic [FW-1:0] frame_q;       // ring slot being walked
  logic [5:0]    pos_q;
  logic [CW-1:0] obj_q;         // next object to read / copy
  logic [OW-1:0] eval_slot_q;
  logic          rd_pend_q;
  fhnm_pkg::in_item_t qry_q;
  logic [23:0]   lim2_q;
  logic          have_q;
  logic [24:0]   best_d_q;
  logic [OW-1:0] best_q;
  fhnm_pkg::obj_t best_obj_q;
  logic          res_valid_q;
  fhnm_pkg::out_item_t res_q;

  function automatic logic [AW-1:0] addr(logic [FW-1:0] f, logic [CW-1:0] o);
    return AW'(f) * AW'(MaxObjects) + AW'(o);
  endfunction

  function automatic logic [FW-1:0] nxt(logic [FW-1:0] f);
    return (f == LastFrame) ? '0 : f + FW'(1);
  endfunction

  logic [11:0] dx, dy;
  logic [23:0] dx2, dy2;
  logic [24:0] d2;
  logic [15:0] rd;
  logic        hit;
  logic [CW-1:0] frame_cnt;
  logic          last_frame;
  logic          res_load;

  assign dx  = (store_rd_q.x > qry_q.center_x) ? store_rd_q.x - qry_q.center_x
                                               : qry_q.center_x - store_rd_q.x;
  assign dy  = (store_rd_q.y > qry_q.center_y) ? store_rd_q.y - qry_q.center_y
                                               : qry_q.center_y - store_rd_q.y;
  assign dx2 = 24'(dx) * 24'(dx);
  assign dy2 = 24'(dy) * 24'(dy);
  assign d2  = {1'b0, dx2} + {1'b0, dy2};
  assign rd  = (store_rd_q.ratio > qry_q.shape_ratio)
             ? store_rd_q.ratio - qry_q.shape_ratio : qry_q.shape_ratio - store_rd_q.ratio;
  assign hit = (d2 < {1'b0, lim2_q}) && (rd < ratio_tol_i) && (!have_q || d2 < best_d_q);
  assign frame_cnt  = cnt_q[frame_q];
  assign last_frame = (pos_q + 6'd1) == 6'(stored_q);
  assign res_load   = (state_q == StEmit) && (!res_valid_q || res_ready_i);

  assign cmd_pop_o   = (state_q == StIdle) && cmd_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (cmd_valid_i) begin
        unique case (cmd_i.operation)
          fhnm_pkg::OpCommit: state_d = StCopy;
          fhnm_pkg::OpQuery:  state_d = (stored_q == '0) ? StEmit : StRead;
          default:            state_d = StIdle;
        endcase
      end
      StCopy: if (obj_q == CW'(MaxObjects)) state_d = StIdle;
      StRead: state_d = (obj_q == frame_cnt) ? StEmit : StEval;
      StEval: state_d = StRead;
      StEmit: if (res_load) state_d = StWait;
      StWait: state_d = (stored_q == '0 || res_q.last) ? StIdle : StRead;
      default: state_d = StIdle;
    endcase
  end

  // store read: one port for query walk and pending copy
  always_ff @(posedge clk_i) begin
    store_rd_q <= store_mem[addr(frame_q, obj_q)];
    pend_rd_q  <= pend_mem[obj_q[OW-1:0]];
    if (rd_pend_q) store_mem[addr(frame_q, obj_q - CW'(1))] <= pend_rd_q;
    if (state_q == StIdle && cmd_valid_i && cmd_i.operation == fhnm_pkg::OpAdd
        && pend_cnt_q < CW'(MaxObjects))
      pend_mem[pend_cnt_q[OW-1:0]] <= '{x: cmd_i.center_x, y: cmd_i.center_y,
                                          ratio: cmd_i.shape_ratio};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      for (int i = 0; i < MemoryFrames; i++) cnt_q[i] <= '0;
      head_q      <= '0;
      stored_q    <= '0;
      pend_cnt_q  <= '0;
      frame_q     <= '0;
      pos_q       <= '0;
      obj_q       <= '0;
      eval_slot_q <= '0;
      rd_pend_q   <= 1'b0;
      have_q      <= 1'b0;
      res_valid_q <= 1'b0;
      qry_q       <= '0;
      lim2_q      <= '0;
      best_d_q    <= '0;
      best_q      <= '0;
      best_obj_q  <= '0;
      res_q       <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == StCopy) && (obj_q != CW'(MaxObjects));
      if (res_load) res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (cmd_valid_i) begin
          obj_q  <= '0;
          have_q <= 1'b0;
          pos_q  <= '0;
          unique case (cmd_i.operation)
            fhnm_pkg::OpAdd:
              if (pend_cnt_q < CW'(MaxObjects)) pend_cnt_q <= pend_cnt_q + CW'(1);
            fhnm_pkg::OpCommit: begin
              frame_q <= head_q;
              cnt_q[head_q] <= pend_cnt_q;
            end
            fhnm_pkg::OpQuery: begin
              qry_q  <= cmd_i;
              lim2_q <= 24'(dist_limit_i) * 24'(dist_limit_i);
              // oldest slot
              frame_q <= (stored_q == NW'(MemoryFrames)) ? head_q
                       : (NW'(head_q) >= stored_q) ? FW'(NW'(head_q) - stored_q)
                       : FW'(NW'(head_q) + NW'(MemoryFrames) - stored_q);
            end
            default: ;
          endcase
        end
        StCopy: begin
          if (obj_q == CW'(MaxObjects)) begin
            head_q     <= nxt(head_q);
            pend_cnt_q <= '0;
            if (stored_q != NW'(MemoryFrames)) stored_q <= stored_q + NW'(1);
          end else begin
            obj_q <= obj_q + CW'(1);
          end
        end
        StRead: if (obj_q != frame_cnt) begin
          eval_slot_q <= obj_q[OW-1:0];
          obj_q       <= obj_q + CW'(1);
        end
        StEval: if (hit) begin
          have_q     <= 1'b1;
          best_d_q   <= d2;
          best_q     <= eval_slot_q;
          best_obj_q <= store_rd_q;
        end
        StEmit: if (res_load) begin
          res_q.found          <= have_q;
          res_q.frame_position <= pos_q;
          res_q.object_slot    <= have_q ? 8'(best_q) : 8'd0;
          res_q.match_x        <= have_q ? best_obj_q.x : 12'd0;
          res_q.match_y        <= have_q ? best_obj_q.y : 12'd0;
          res_q.match_ratio    <= have_q ? best_obj_q.ratio : 16'd0;
          res_q.last           <= (stored_q == '0) || last_frame;
        end
        StWait: if (!(stored_q == '0 || res_q.last)) begin
          // on to the next frame
          frame_q <= nxt(frame_q);
          pos_q   <= pos_q + 6'd1;
          obj_q   <= '0;
          have_q  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  `FHNM_ASSERT(a_count_bound, clk_i, rst_ni, pend_cnt_q <= CW'(MaxObjects))
  `FHNM_ASSERT(a_stored_bound, clk_i, rst_ni, stored_q <= NW'(MemoryFrames))
  `FHNM_ASSERT(a_res_hold, clk_i, rst_ni,
    res_valid_q && !res_ready_i |=> res_valid_q && $stable(res_q))
endmodule

/* rtl/core/frame_history_nearest_match.sv */
// Frame history nearest match. Objects (op add) fill a pending frame of up to
// MaxObjects entries; a commit copies it into a ring of MemoryFrames frames
// over the single store port. A query walks every stored object and returns
// one result per stored frame, oldest first, with last set on the final one
// (one not-found result when the ring is empty). Inputs pass through a
// two-entry queue so the front keeps taking items while the back end is busy.
// Registers: index 0 distance limit, index 1 ratio tolerance.
module frame_history_nearest_match #(
  parameter int unsigned MemoryFrames = fhnm_pkg::MemoryFramesDefault,
  parameter int unsigned MaxObjects   = fhnm_pkg::MaxObjectsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fhnm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fhnm_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  fhnm_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output fhnm_pkg::out_item_t               out_data_o
);
  logic [11:0] dist_limit_q;
  logic [15:0] ratio_tol_q;
  logic full, empty, pop;
  fhnm_pkg::in_item_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_limit_q <= fhnm_pkg::DistLimitReset;
      ratio_tol_q  <= fhnm_pkg::RatioTolReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fhnm_pkg::CfgDistLimit: dist_limit_q <= cfg_data_i[11:0];
        fhnm_pkg::CfgRatioTol:  ratio_tol_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !full;

  fhnm_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (in_valid_i && in_data_i.operation != fhnm_pkg::OpNop),
    .push_data_i (in_data_i),
    .full_o      (full),
    .empty_o     (empty),
    .pop_i       (pop),
    .pop_data_o  (head)
  );

  fhnm_back #(.MemoryFrames(MemoryFrames), .MaxObjects(MaxObjects)) u_back (
    .clk_i, .rst_ni,
    .dist_limit_i (dist_limit_q),
    .ratio_tol_i  (ratio_tol_q),
    .cmd_valid_i  (!empty),
    .cmd_i        (head),
    .cmd_pop_o    (pop),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (out_data_o)
  );
endmodule
